// ----- rtl/pil_pkg.sv -----
`timescale 1ns / 1ps
package pil_pkg;

	localparam int NUM_IRQS   = 1024;
	localparam int WORD_BITS  = 64;
	localparam int WORDS      = (NUM_IRQS + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BIT_IDX_W  = $clog2(WORD_BITS);
	localparam int IRQ_W      = 10;
	localparam int CMD_W      = 2;

	localparam logic [CMD_W-1:0] CMD_POST  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_PULL  = 2'd2;

	localparam logic STAGE_ROOT = 1'b0;
	localparam logic STAGE_HEAD = 1'b1;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic             stage_sel;
		logic [IRQ_W-1:0] irq_number;
	} pil_req_t;

	typedef struct packed {
		logic [IRQ_W-1:0] pulled_irq;
		logic             found;
	} pil_rsp_t;

	// per stage operation; post and clear already qualified by valid and range, pull by valid
	typedef struct packed {
		logic                 post;
		logic                 clr;
		logic                 pull;
		logic [WIDX_W-1:0]    word_idx;
		logic [BIT_IDX_W-1:0] bit_idx;
	} pil_op_t;

	typedef struct packed {
		logic                 found;
		logic [WIDX_W-1:0]    word_idx;
		logic [BIT_IDX_W-1:0] bit_idx;
	} pil_hit_t;

endpackage

// ----- rtl/two_level_pending_interrupt_log_top.sv -----
`timescale 1ns / 1ps
// channel   | ports                    | handshake
// ----------+--------------------------+----------------------------------
// command   | request (pil_req_t)      | taken when start high, busy low
// result    | result (pil_rsp_t)       | one cycle, marked by done
//
// one transaction per cycle; busy stays low
// done and result come from the result register, which follows the command register
// the state update and the pull search sit between the command register and
// the result register: summary encode, word select, lowest bit encode
// reset clears both logs at once, no clearing pass
// the receiver cannot stall; done is a single cycle strobe
module two_level_pending_interrupt_log_top import pil_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  pil_req_t request,
	output logic     done,
	output pil_rsp_t result
);

	logic     valid_s1;
	pil_req_t req_s1;
	logic     done_s2;
	pil_rsp_t result_s2;

	logic     in_range;
	pil_op_t  op_root;
	pil_op_t  op_head;
	pil_hit_t hit_root;
	pil_hit_t hit_head;
	pil_hit_t hit_sel;
	logic     is_pull;
	pil_rsp_t rsp_next;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			req_s1 <= request;
		end
	end

	always_comb begin
		in_range = 32'(req_s1.irq_number) < NUM_IRQS;
		is_pull  = valid_s1 && (req_s1.command == CMD_PULL);

		op_root.word_idx = WIDX_W'(req_s1.irq_number / WORD_BITS);
		op_root.bit_idx  = BIT_IDX_W'(req_s1.irq_number % WORD_BITS);
		op_root.post     = valid_s1 && in_range && (req_s1.command == CMD_POST) &&
			(req_s1.stage_sel == STAGE_ROOT);
		op_root.clr      = valid_s1 && in_range && (req_s1.command == CMD_CLEAR);
		op_root.pull     = is_pull && (req_s1.stage_sel == STAGE_ROOT);

		op_head          = op_root;
		op_head.post     = valid_s1 && in_range && (req_s1.command == CMD_POST) &&
			(req_s1.stage_sel == STAGE_HEAD);
		op_head.pull     = is_pull && (req_s1.stage_sel == STAGE_HEAD);
	end

	pil_stage u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_root),
		.hit    (hit_root)
	);

	pil_stage u_head (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op_head),
		.hit    (hit_head)
	);

	always_comb begin
		hit_sel = (req_s1.stage_sel == STAGE_HEAD) ? hit_head : hit_root;
		rsp_next = '0;
		if (is_pull && hit_sel.found) begin
			rsp_next.found      = 1'b1;
			rsp_next.pulled_irq = IRQ_W'(32'(hit_sel.word_idx) * WORD_BITS +
				32'(hit_sel.bit_idx));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s2 <= 1'b0;
		end else begin
			done_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		result_s2 <= rsp_next;
	end

	assign done   = done_s2;
	assign result = result_s2;

	a_done_follows_valid: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done_s2)
		else $error("transaction without result");

	a_found_only_on_pull: assert property (@(posedge clk) disable iff (!arst_n)
		result_s2.found |-> $past(is_pull))
		else $error("found set for a command other than pull");

	a_zero_when_missing: assert property (@(posedge clk) disable iff (!arst_n)
		(done_s2 && !result_s2.found) |-> (result_s2.pulled_irq == '0))
		else $error("nonzero interrupt without found");

endmodule

// ----- rtl/pil_stage.sv -----
`timescale 1ns / 1ps
module pil_stage import pil_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  pil_op_t  op,
	output pil_hit_t hit
);

	logic [WORDS-1:0]     summary_q;
	logic [WORD_BITS-1:0] words_q [WORDS];

	logic [WIDX_W-1:0]    first_w;
	logic [WIDX_W-1:0]    addr;
	logic [WORD_BITS-1:0] rd_word;
	logic [WORD_BITS-1:0] new_word;
	logic [WORD_BITS-1:0] clr_mask;
	logic [BIT_IDX_W-1:0] low_b;
	logic                 found;
	logic                 wr_en;

	always_comb begin
		first_w = '0;
		for (int i = WORDS - 1; i >= 0; i--) begin
			if (summary_q[i]) begin
				first_w = WIDX_W'(i);
			end
		end
	end

	// one read address: pull word or the word of the interrupt number
	assign addr    = op.pull ? first_w : op.word_idx;
	assign rd_word = words_q[addr];

	always_comb begin
		low_b = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (rd_word[i]) begin
				low_b = BIT_IDX_W'(i);
			end
		end
	end

	assign found = (|summary_q) && (|rd_word);

	always_comb begin
		clr_mask = WORD_BITS'(1) << (op.pull ? low_b : op.bit_idx);
		if (op.post) begin
			new_word = rd_word | clr_mask;
		end else begin
			new_word = rd_word & ~clr_mask;
		end
		wr_en = op.post || op.clr || (op.pull && found);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			summary_q <= '0;
			for (int i = 0; i < WORDS; i++) begin
				words_q[i] <= '0;
			end
		end else if (wr_en) begin
			words_q[addr]   <= new_word;
			summary_q[addr] <= op.post || (new_word != '0);
		end
	end

	assign hit.found    = found;
	assign hit.word_idx = first_w;
	assign hit.bit_idx  = low_b;

	a_found_needs_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(op.pull && hit.found) |-> (summary_q != '0))
		else $error("pull hit with empty summary");

	a_post_sets_summary: assert property (@(posedge clk) disable iff (!arst_n)
		op.post |=> summary_q[$past(op.word_idx)])
		else $error("summary bit not set after post");

	a_post_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		op.post |=> words_q[$past(op.word_idx)][$past(op.bit_idx)])
		else $error("pending bit not set after post");

endmodule

// ----- tb/pil_log_checker.sv -----
`timescale 1ns / 1ps
module pil_log_checker import pil_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     busy,
	input  pil_req_t request,
	input  logic     done,
	input  pil_rsp_t result,
	output int       fail_count,
	output int       waiting,
	output int       checked,
	output int       hits
);

	logic [WORD_BITS-1:0] pending_bits [2][WORDS];
	logic [WORDS-1:0]     summary_bits [2];
	pil_rsp_t             expected_results [$];
	pil_rsp_t             want;
	pil_rsp_t             next_rsp;

	task automatic drop_irq(input logic stg, input int irq);
		int w;
		int b;
		w = irq / WORD_BITS;
		b = irq % WORD_BITS;
		pending_bits[stg][w][b] = 1'b0;
		if (pending_bits[stg][w] == '0) begin
			summary_bits[stg][w] = 1'b0;
		end
	endtask

	task automatic predict_log(input pil_req_t req, output pil_rsp_t rsp);
		int irq;
		int w;
		int b;
		int first;
		logic stg;
		rsp = '0;
		irq = int'(req.irq_number);
		stg = req.stage_sel;
		case (req.command)
			CMD_POST: begin
				if (irq < NUM_IRQS) begin
					pending_bits[stg][irq / WORD_BITS][irq % WORD_BITS] = 1'b1;
					summary_bits[stg][irq / WORD_BITS] = 1'b1;
				end
			end
			CMD_CLEAR: begin
				if (irq < NUM_IRQS) begin
					drop_irq(STAGE_ROOT, irq);
					drop_irq(STAGE_HEAD, irq);
				end
			end
			CMD_PULL: begin
				first = WORDS;
				for (w = WORDS - 1; w >= 0; w--) begin
					if (summary_bits[stg][w]) first = w;
				end
				if (first < WORDS && pending_bits[stg][first] != '0) begin
					b = 0;
					while (b < WORD_BITS - 1 && !pending_bits[stg][first][b]) b++;
					drop_irq(stg, first * WORD_BITS + b);
					rsp.pulled_irq = IRQ_W'(first * WORD_BITS + b);
					rsp.found      = 1'b1;
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			foreach (pending_bits[s, w]) pending_bits[s][w] = '0;
			summary_bits[0] = '0;
			summary_bits[1] = '0;
			expected_results.delete();
			fail_count = 0;
			checked = 0;
			hits = 0;
		end else begin
			if (done) begin
				if (expected_results.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%t: result with no transaction pending: irq %0d found %0b",
							$realtime, result.pulled_irq, result.found);
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (want.found) hits++;
					if (result.pulled_irq !== want.pulled_irq || result.found !== want.found) begin
						fail_count++;
						if (fail_count <= 10)
							$display("%t: mismatch: expected irq %0d found %0b, got irq %0d found %0b",
								$realtime, want.pulled_irq, want.found,
								result.pulled_irq, result.found);
					end
				end
			end
			if (start && !busy) begin
				predict_log(request, next_rsp);
				expected_results.push_back(next_rsp);
			end
		end
		waiting = expected_results.size();
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import pil_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam int STALL_LIMIT = 1000;

	logic     clk = 1'b0;
	logic     arst_n = 1'b0;
	logic     start = 1'b0;
	pil_req_t request = '0;
	logic     busy;
	logic     done;
	pil_rsp_t result;

	int fail_count;
	int waiting;
	int checked;
	int hits;
	int idle_cycles = 0;
	int sent = 0;
	int recent [8] = '{default: 0};
	bit gaps_on = 1'b1;

	always #1 clk = ~clk;

	two_level_pending_interrupt_log_top u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.busy    (busy),
		.request (request),
		.done    (done),
		.result  (result)
	);

	pil_log_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.request    (request),
		.done       (done),
		.result     (result),
		.fail_count (fail_count),
		.waiting    (waiting),
		.checked    (checked),
		.hits       (hits)
	);

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("two_level_pending_interrupt_log_top regression: fail");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_cmd(input logic [CMD_W-1:0] cmd, input logic stg,
		input logic [IRQ_W-1:0] irq);
		int gap;
		gap = gaps_on ? int'($urandom_range(0, 4)) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start   <= 1'b1;
		request <= '{command: cmd, stage_sel: stg, irq_number: irq};
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic settle();
		start <= 1'b0;
		@(negedge clk);
		while (waiting != 0) @(negedge clk);
		@(posedge clk);
	endtask

	task automatic random_cmd(input int lo, input int hi);
		int r;
		int irq;
		logic stg;
		r   = $urandom_range(0, 99);
		stg = 1'($urandom_range(0, 1));
		irq = $urandom_range(lo, hi);
		if (r < 42) begin
			recent[$urandom_range(0, 7)] = irq;
			send_cmd(CMD_POST, stg, IRQ_W'(irq));
		end else if (r < 56) begin
			// mostly clear something that was posted lately
			if ($urandom_range(0, 9) < 7) irq = recent[$urandom_range(0, 7)];
			send_cmd(CMD_CLEAR, stg, IRQ_W'(irq));
		end else if (r < 95) begin
			send_cmd(CMD_PULL, stg, IRQ_W'(irq));
		end else begin
			send_cmd(CMD_UNUSED, stg, IRQ_W'(irq));
		end
	endtask

	initial begin
		int lo;
		int hi;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// word edges, priority order, empty pulls
		send_cmd(CMD_POST, STAGE_ROOT, 10'd0);
		send_cmd(CMD_POST, STAGE_ROOT, 10'd1023);
		send_cmd(CMD_POST, STAGE_ROOT, 10'd63);
		send_cmd(CMD_POST, STAGE_ROOT, 10'd64);
		send_cmd(CMD_PULL, STAGE_ROOT, 10'd0);
		send_cmd(CMD_PULL, STAGE_ROOT, 10'd1023);
		send_cmd(CMD_PULL, STAGE_ROOT, 10'd0);
		send_cmd(CMD_PULL, STAGE_ROOT, 10'd0);
		send_cmd(CMD_PULL, STAGE_ROOT, 10'd0);
		// clear hits both stages
		send_cmd(CMD_POST, STAGE_HEAD, 10'h2AA);
		send_cmd(CMD_POST, STAGE_HEAD, 10'h155);
		send_cmd(CMD_POST, STAGE_ROOT, 10'h155);
		send_cmd(CMD_CLEAR, STAGE_HEAD, 10'h155);
		send_cmd(CMD_PULL, STAGE_HEAD, 10'h3FF);
		send_cmd(CMD_PULL, STAGE_HEAD, 10'h3FF);
		send_cmd(CMD_PULL, STAGE_ROOT, 10'h3FF);
		// clear leaves summary set while the word still holds a bit
		send_cmd(CMD_POST, STAGE_HEAD, 10'd130);
		send_cmd(CMD_POST, STAGE_HEAD, 10'd131);
		send_cmd(CMD_CLEAR, STAGE_ROOT, 10'd130);
		send_cmd(CMD_PULL, STAGE_HEAD, 10'd0);
		send_cmd(CMD_UNUSED, STAGE_HEAD, 10'd1023);
		send_cmd(CMD_CLEAR, STAGE_ROOT, 10'd5);
		send_cmd(CMD_POST, STAGE_HEAD, 10'd1023);
		send_cmd(CMD_PULL, STAGE_HEAD, 10'd0);
		settle();

		for (int p = 0; p < 5; p++) begin
			gaps_on = (p % 2 == 0);
			case (p)
				0: begin
					lo = 0;
					hi = 127;
				end
				2: begin
					lo = 896;
					hi = 1023;
				end
				3: begin
					lo = 48;
					hi = 79;
				end
				default: begin
					lo = 0;
					hi = NUM_IRQS - 1;
				end
			endcase
			repeat (170) random_cmd(lo, hi);
			settle();
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		$display("sent %0d commands across five irq windows with and without gaps", sent);
		$display("checked %0d results, %0d pulls returned an interrupt", checked, hits);
		if (fail_count == 0) begin
			$display("two_level_pending_interrupt_log_top regression: pass");
		end else begin
			$display("two_level_pending_interrupt_log_top regression: fail");
		end
		$finish;
	end

endmodule
